// ----- rtl/core/rounded_rect_fan_tessellator_unit_defines.svh -----
// Assertion macros for the rounded-rectangle fan tessellator checker.
// Each macro expects i_clk and i_rst_n in scope where it is used.
`ifndef ROUNDED_RECT_FAN_TESSELLATOR_UNIT_DEFINES_SVH
`define ROUNDED_RECT_FAN_TESSELLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RRFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RRFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rrft_pkg.sv -----
// Shared types, constants and helper functions of the fan tessellator.
// No dependencies; imported by the top, front-end and back-end modules and the testbench.
`default_nettype none

package rrft_pkg;

    localparam int CORNER_SEGMENTS = 8;
    localparam int VERTEX_CAPACITY = 65536;
    localparam int INDEX_CAPACITY  = 196608;

    localparam int PTS    = 4 * (CORNER_SEGMENTS + 1);
    localparam int STEP_W = $clog2(CORNER_SEGMENTS + 1);
    localparam int IDX_W  = $clog2(PTS);

    localparam int REQ_Q_DEPTH = 2;
    localparam int REQ_PTR_W   = $clog2(REQ_Q_DEPTH);
    localparam int REQ_CNT_W   = $clog2(REQ_Q_DEPTH + 1);
    localparam int OUT_Q_DEPTH = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_Q_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_Q_DEPTH + 1);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        CRN_TL,
        CRN_TR,
        CRN_BR,
        CRN_BL
    } t_corner;

    typedef enum logic {
        SEQ_CENTRE,
        SEQ_PERIM
    } t_seq_state;

    // Request descriptor handed from the front end to the back end
    typedef struct packed {
        logic                ovf;
        logic [15:0]         base;
        logic [31:0]         color;
        logic signed [15:0]  cen_x;
        logic signed [15:0]  cen_y;
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic [14:0]         width;
        logic [14:0]         height;
        logic [3:0][14:0]    rad;
    } t_req;

    typedef struct packed {
        logic signed [15:0]  vertex_x;
        logic signed [15:0]  vertex_y;
        logic [31:0]         vertex_color;
        logic                has_triangle;
        logic [15:0]         tri_center;
        logic [15:0]         tri_first;
        logic [15:0]         tri_second;
        logic                overflow;
        logic                last;
    } t_result;

    typedef logic [14:0] t_sin_rom [0:CORNER_SEGMENTS];

    // sin(k*90/S deg) in Q1.14 via a Q30 Taylor series; elaboration only
    function automatic logic [14:0] quarter_sin(input int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          q;
        x    = (HALF_PI_Q30 * 64'(k) + 64'(CORNER_SEGMENTS / 2)) / 64'(CORNER_SEGMENTS);
        sum  = longint'(x);
        term = x;
        for (int n = 1; n <= 12; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (sum + 32768) >>> 16;
        if (q > 16384) begin
            q = 16384;
        end
        return 15'(q);
    endfunction

    function automatic t_sin_rom build_sin_rom();
        t_sin_rom rom;
        for (int k = 0; k <= CORNER_SEGMENTS; k++) begin
            rom[k] = quarter_sin(k);
        end
        return rom;
    endfunction

    localparam t_sin_rom SIN_ROM = build_sin_rom();

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rounded_rect_fan_tessellator_unit.sv -----
// Rounded-rectangle fan tessellator. Requests enter a two-entry queue one per
// cycle while it has room; the back end then emits 1 + 4*(CORNER_SEGMENTS+1)
// results per request (37 at 8 segments), one per cycle while the result queue
// has room, or a single overflow result when the request is dropped for lack of
// vertex or index capacity. The first result of a request passes through the
// request queue, the r_s1 and r_s2 pipeline registers and the result queue.
// A four-entry result queue lets the block keep working while results wait
// to be popped. Depends on rrft_pkg, rrft_front and rrft_back.
`default_nettype none

module rounded_rect_fan_tessellator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_new_frame,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic [14:0]         i_width,
    input  logic [14:0]         i_height,
    input  logic [14:0]         i_radius_top_left,
    input  logic [14:0]         i_radius_top_right,
    input  logic [14:0]         i_radius_bottom_right,
    input  logic [14:0]         i_radius_bottom_left,
    input  logic [31:0]         i_fill_color,
    output logic                empty,
    input  logic                pop,
    output logic signed [15:0]  o_vertex_x,
    output logic signed [15:0]  o_vertex_y,
    output logic [31:0]         o_vertex_color,
    output logic                o_has_triangle,
    output logic [15:0]         o_tri_center,
    output logic [15:0]         o_tri_first,
    output logic [15:0]         o_tri_second,
    output logic                o_overflow,
    output logic                o_last
);
    import rrft_pkg::*;

    t_req     head;
    logic     head_valid;
    logic     head_pop;
    t_result  result;

    rrft_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_push                (push),
        .o_full                (full),
        .i_new_frame           (i_new_frame),
        .i_pos_x               (i_pos_x),
        .i_pos_y               (i_pos_y),
        .i_width               (i_width),
        .i_height              (i_height),
        .i_radius_top_left     (i_radius_top_left),
        .i_radius_top_right    (i_radius_top_right),
        .i_radius_bottom_right (i_radius_bottom_right),
        .i_radius_bottom_left  (i_radius_bottom_left),
        .i_fill_color          (i_fill_color),
        .o_head                (head),
        .o_head_valid          (head_valid),
        .i_head_pop            (head_pop)
    );

    rrft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_head_pop   (head_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (result)
    );

    assign o_vertex_x     = result.vertex_x;
    assign o_vertex_y     = result.vertex_y;
    assign o_vertex_color = result.vertex_color;
    assign o_has_triangle = result.has_triangle;
    assign o_tri_center   = result.tri_center;
    assign o_tri_first    = result.tri_first;
    assign o_tri_second   = result.tri_second;
    assign o_overflow     = result.overflow;
    assign o_last         = result.last;

endmodule

`default_nettype wire

// ----- rtl/core/rrft_front.sv -----
// Front end: accepts requests, checks capacity, keeps the vertex and index
// counts, clamps radii and queues descriptors. Depends on rrft_pkg.
`default_nettype none

module rrft_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_new_frame,
    input  logic signed [15:0]   i_pos_x,
    input  logic signed [15:0]   i_pos_y,
    input  logic [14:0]          i_width,
    input  logic [14:0]          i_height,
    input  logic [14:0]          i_radius_top_left,
    input  logic [14:0]          i_radius_top_right,
    input  logic [14:0]          i_radius_bottom_right,
    input  logic [14:0]          i_radius_bottom_left,
    input  logic [31:0]          i_fill_color,
    output rrft_pkg::t_req       o_head,
    output logic                 o_head_valid,
    input  logic                 i_head_pop
);
    import rrft_pkg::*;

    logic [16:0]           r_vertex_count, n_vertex_count;
    logic [17:0]           r_index_count, n_index_count;
    logic [16:0]           vc_eff;
    logic [17:0]           ic_eff;
    logic [19:0]           vc_sum, ic_sum;
    logic                  ovf, accept;
    logic [14:0]           min_side;
    logic [3:0][14:0]      radius_in;
    logic signed [17:0]    cen_sum_x, cen_sum_y;
    t_req                  req;

    t_req                  r_q [REQ_Q_DEPTH];
    logic [REQ_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [REQ_CNT_W-1:0]  r_count;

    assign o_full       = (r_count == REQ_CNT_W'(REQ_Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];
    assign accept       = i_push && !o_full;

    // new_frame clears the counts ahead of the capacity check
    assign vc_eff = i_new_frame ? '0 : r_vertex_count;
    assign ic_eff = i_new_frame ? '0 : r_index_count;
    assign vc_sum = {3'b0, vc_eff} + 20'(PTS + 1);
    assign ic_sum = {2'b0, ic_eff} + 20'(3 * PTS);
    assign ovf    = (vc_sum > 20'(VERTEX_CAPACITY)) || (ic_sum > 20'(INDEX_CAPACITY));

    assign n_vertex_count = accept ? (ovf ? vc_eff : vc_sum[16:0]) : r_vertex_count;
    assign n_index_count  = accept ? (ovf ? ic_eff : ic_sum[17:0]) : r_index_count;

    assign min_side  = (i_width < i_height) ? i_width : i_height;
    assign radius_in = {i_radius_bottom_left, i_radius_bottom_right,
                        i_radius_top_right, i_radius_top_left};

    // centre in 1/32 units: 2x+w, 2y+h
    assign cen_sum_x = $signed({i_pos_x[15], i_pos_x, 1'b0}) + $signed({3'b0, i_width});
    assign cen_sum_y = $signed({i_pos_y[15], i_pos_y, 1'b0}) + $signed({3'b0, i_height});

    always_comb begin
        req        = '0;
        req.ovf    = ovf;
        req.base   = vc_eff[15:0];
        req.color  = i_fill_color;
        req.pos_x  = i_pos_x;
        req.pos_y  = i_pos_y;
        req.width  = i_width;
        req.height = i_height;
        req.cen_x  = sat16($signed({{3{cen_sum_x[17]}}, cen_sum_x[17:1]})
                           + 20'sd0 + $signed({19'b0, cen_sum_x[0]}));
        req.cen_y  = sat16($signed({{3{cen_sum_y[17]}}, cen_sum_y[17:1]})
                           + 20'sd0 + $signed({19'b0, cen_sum_y[0]}));
        for (int c = 0; c < 4; c++) begin
            // clamp 2r to the smaller side (units of 1/32)
            if ({radius_in[c], 1'b0} < {1'b0, min_side}) begin
                req.rad[c] = {radius_in[c][13:0], 1'b0};
            end else begin
                req.rad[c] = min_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_index_count  <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            r_vertex_count <= n_vertex_count;
            r_index_count  <= n_index_count;
            if (accept) begin
                r_wr_ptr <= (r_wr_ptr == REQ_PTR_W'(REQ_Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_head_pop) begin
                r_rd_ptr <= (r_rd_ptr == REQ_PTR_W'(REQ_Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + REQ_CNT_W'(accept) - REQ_CNT_W'(i_head_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= req;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rrft_back.sv -----
// Back end: walks each queued request, emits the centre and perimeter
// vertices (or an overflow marker for a dropped request) through a two-stage
// multiply pipeline into a result queue. Depends on rrft_pkg.
`default_nettype none

module rrft_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrft_pkg::t_req     i_head,
    input  logic               i_head_valid,
    output logic               o_head_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output rrft_pkg::t_result  o_result
);
    import rrft_pkg::*;

    typedef struct packed {
        t_result             res;
        logic                direct;
        t_corner             corner;
        logic signed [18:0]  cx;
        logic signed [18:0]  cy;
        logic [14:0]         rad;
        logic [14:0]         qc;
        logic [14:0]         qs;
    } t_pt_op;

    typedef struct packed {
        t_result             res;
        logic                direct;
        t_corner             corner;
        logic signed [18:0]  cx;
        logic signed [18:0]  cy;
        logic [29:0]         pa;
        logic [29:0]         pb;
    } t_pt_prod;

    t_seq_state            r_state, n_state;
    t_corner               r_corner, n_corner;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [IDX_W-1:0]      r_idx, n_idx;

    logic                  can_issue, issue, last_pt, step_end;
    logic [OUT_CNT_W:0]    in_use;
    t_pt_op                op;
    logic                  r_s1_valid, r_s2_valid;
    t_pt_op                r_s1;
    t_pt_prod              r_s2;

    logic signed [18:0]    px2, py2, w2, h2, radx;
    logic signed [34:0]    term_x, term_y, sum_x, sum_y;
    t_result               push_res;
    logic                  pop_ok;

    t_result               r_oq [OUT_Q_DEPTH];
    logic [OUT_PTR_W-1:0]  r_owr, r_ord;
    logic [OUT_CNT_W-1:0]  r_ocnt;

    // Only issue when a slot is guaranteed for everything in flight
    assign in_use    = {1'b0, r_ocnt} + (OUT_CNT_W + 1)'(r_s1_valid)
                       + (OUT_CNT_W + 1)'(r_s2_valid);
    assign can_issue = (in_use < (OUT_CNT_W + 1)'(OUT_Q_DEPTH));
    assign last_pt   = (r_idx == IDX_W'(PTS - 1));
    assign step_end  = (r_step == STEP_W'(CORNER_SEGMENTS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_CENTRE: begin
                if (i_head_valid && can_issue && !i_head.ovf) begin
                    n_state = SEQ_PERIM;
                end
            end
            SEQ_PERIM: begin
                if (can_issue && last_pt) begin
                    n_state = SEQ_CENTRE;
                end
            end
            default: n_state = SEQ_CENTRE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        issue      = 1'b0;
        o_head_pop = 1'b0;
        n_corner   = r_corner;
        n_step     = r_step;
        n_idx      = r_idx;
        case (r_state)
            SEQ_CENTRE: begin
                issue      = i_head_valid && can_issue;
                o_head_pop = issue && i_head.ovf;
            end
            SEQ_PERIM: begin
                issue      = can_issue;
                o_head_pop = can_issue && last_pt;
                if (can_issue) begin
                    // counters return to zero after the final point
                    n_idx = last_pt ? '0 : r_idx + 1'b1;
                    if (step_end) begin
                        n_step   = '0;
                        n_corner = t_corner'(r_corner + 2'd1);
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign px2  = $signed({{2{i_head.pos_x[15]}}, i_head.pos_x, 1'b0});
    assign py2  = $signed({{2{i_head.pos_y[15]}}, i_head.pos_y, 1'b0});
    assign w2   = $signed({3'b0, i_head.width, 1'b0});
    assign h2   = $signed({3'b0, i_head.height, 1'b0});
    assign radx = $signed({4'b0, i_head.rad[r_corner]});

    // issue datapath
    always_comb begin
        op                  = '0;
        op.corner           = r_corner;
        op.rad              = i_head.rad[r_corner];
        op.qs               = SIN_ROM[r_step];
        op.qc               = SIN_ROM[STEP_W'(CORNER_SEGMENTS) - r_step];
        op.res.vertex_color = i_head.color;
        if (r_corner == CRN_TR || r_corner == CRN_BR) begin
            op.cx = px2 + w2 - radx;
        end else begin
            op.cx = px2 + radx;
        end
        if (r_corner == CRN_BR || r_corner == CRN_BL) begin
            op.cy = py2 + h2 - radx;
        end else begin
            op.cy = py2 + radx;
        end
        if (r_state == SEQ_CENTRE) begin
            op.direct = 1'b1;
            if (i_head.ovf) begin
                op.res          = '0;
                op.res.overflow = 1'b1;
                op.res.last     = 1'b1;
            end else begin
                op.res.vertex_x = i_head.cen_x;
                op.res.vertex_y = i_head.cen_y;
            end
        end else begin
            op.res.has_triangle = 1'b1;
            op.res.tri_center   = i_head.base;
            op.res.tri_first    = i_head.base + 16'(r_idx) + 16'd1;
            op.res.tri_second   = last_pt ? i_head.base + 16'd1
                                          : i_head.base + 16'(r_idx) + 16'd2;
            op.res.last         = last_pt;
        end
    end

    // stage 3: add corner centre, round half up, saturate
    always_comb begin
        term_x = '0;
        term_y = '0;
        case (r_s2.corner)
            CRN_TL: begin
                term_x = -$signed({5'b0, r_s2.pa});
                term_y = -$signed({5'b0, r_s2.pb});
            end
            CRN_TR: begin
                term_x = $signed({5'b0, r_s2.pb});
                term_y = -$signed({5'b0, r_s2.pa});
            end
            CRN_BR: begin
                term_x = $signed({5'b0, r_s2.pa});
                term_y = $signed({5'b0, r_s2.pb});
            end
            CRN_BL: begin
                term_x = -$signed({5'b0, r_s2.pb});
                term_y = $signed({5'b0, r_s2.pa});
            end
            default: begin
                term_x = '0;
                term_y = '0;
            end
        endcase
        sum_x = $signed({{2{r_s2.cx[18]}}, r_s2.cx, 14'b0}) + term_x + 35'sd16384;
        sum_y = $signed({{2{r_s2.cy[18]}}, r_s2.cy, 14'b0}) + term_y + 35'sd16384;
        push_res = r_s2.res;
        if (!r_s2.direct) begin
            push_res.vertex_x = sat16($signed(sum_x[34:15]));
            push_res.vertex_y = sat16($signed(sum_y[34:15]));
        end
    end

    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_oq[r_ord];
    assign pop_ok   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SEQ_CENTRE;
            r_corner   <= CRN_TL;
            r_step     <= '0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_owr      <= '0;
            r_ord      <= '0;
            r_ocnt     <= '0;
        end else begin
            r_state    <= n_state;
            r_corner   <= n_corner;
            r_step     <= n_step;
            r_idx      <= n_idx;
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                r_owr <= (r_owr == OUT_PTR_W'(OUT_Q_DEPTH - 1)) ? '0 : r_owr + 1'b1;
            end
            if (pop_ok) begin
                r_ord <= (r_ord == OUT_PTR_W'(OUT_Q_DEPTH - 1)) ? '0 : r_ord + 1'b1;
            end
            r_ocnt <= r_ocnt + OUT_CNT_W'(r_s2_valid) - OUT_CNT_W'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1        <= op;
        r_s2.res    <= r_s1.res;
        r_s2.direct <= r_s1.direct;
        r_s2.corner <= r_s1.corner;
        r_s2.cx     <= r_s1.cx;
        r_s2.cy     <= r_s1.cy;
        r_s2.pa     <= r_s1.rad * r_s1.qc;
        r_s2.pb     <= r_s1.rad * r_s1.qs;
        if (r_s2_valid) begin
            r_oq[r_owr] <= push_res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rrft_checker.sv -----
// Port-level checker for the fan tessellator, bound to the top level.
// Uses the assertion macros from rounded_rect_fan_tessellator_unit_defines.svh.
`default_nettype none
`include "rounded_rect_fan_tessellator_unit_defines.svh"

module rrft_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                empty,
    input  logic                pop,
    input  logic                o_has_triangle,
    input  logic [15:0]         o_tri_center,
    input  logic [15:0]         o_tri_first,
    input  logic [15:0]         o_tri_second,
    input  logic                o_overflow,
    input  logic                o_last
);

    // a dropped request is a single bare result
    `RRFT_ASSERT_NOW(a_ovf_alone, !empty && o_overflow, o_last && !o_has_triangle && o_tri_first == 16'd0, "overflow result not bare")

    `RRFT_ASSERT_NOW(a_tri_sane, !empty && o_has_triangle, !o_overflow && o_tri_first != o_tri_center, "bad perimeter triangle")

    // fan continuity: next point starts where this triangle ended
    `RRFT_ASSERT_NEXT(a_fan_chain, pop && !empty && o_has_triangle && !o_last, empty || (o_has_triangle && o_tri_first == $past(o_tri_second)), "fan broken between points")

    // a new request always opens with a centre or overflow result
    `RRFT_ASSERT_NEXT(a_req_start, pop && !empty && o_last, empty || !o_has_triangle, "request did not open with centre")

endmodule

bind rounded_rect_fan_tessellator_unit rrft_checker u_rrft_checker (.*);

`default_nettype wire

// ----- verif/rounded_rect_fan_tessellator_unit_test.sv -----
// Self-checking testbench for rounded_rect_fan_tessellator_unit: drives rectangle
// requests, predicts each triangle fan and compares every popped vertex result.
// Depends on rrft_pkg and the tessellator RTL.
`timescale 1ns / 100ps

module rounded_rect_fan_tessellator_unit_test;

    import rrft_pkg::*;

    localparam int     FAN_PTS     = 4 * (CORNER_SEGMENTS + 1);
    localparam longint Q14_ONE     = 16384;
    localparam int     STALL_LIMIT = 3000;
    localparam int     HOLD_OFF    = 400;
    localparam int     FRAME_RUN   = 40;
    localparam int     RANDOM_REQS = 240;

    typedef struct packed {
        bit               new_frame;
        bit signed [15:0] pos_x;
        bit signed [15:0] pos_y;
        bit [14:0]        width;
        bit [14:0]        height;
        bit [3:0][14:0]   rad;      // TL, TR, BR, BL
        bit [31:0]        color;
    } t_rect_req;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_new_frame;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic [14:0]        i_width;
    logic [14:0]        i_height;
    logic [14:0]        i_radius_top_left;
    logic [14:0]        i_radius_top_right;
    logic [14:0]        i_radius_bottom_right;
    logic [14:0]        i_radius_bottom_left;
    logic [31:0]        i_fill_color;
    logic               empty;
    logic               pop;
    logic signed [15:0] o_vertex_x;
    logic signed [15:0] o_vertex_y;
    logic [31:0]        o_vertex_color;
    logic               o_has_triangle;
    logic [15:0]        o_tri_center;
    logic [15:0]        o_tri_first;
    logic [15:0]        o_tri_second;
    logic               o_overflow;
    logic               o_last;

    t_result     fan_expected [$];
    t_result     want_res;
    longint      sine_lut [0:CORNER_SEGMENTS];
    longint      vtx_used;
    longint      idx_used;
    int unsigned fails;
    int unsigned quiet_cycles;
    int unsigned sink_hold;
    bit          src_idle;
    bit          sink_idle;

    rounded_rect_fan_tessellator_unit uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .push                  (push),
        .full                  (full),
        .i_new_frame           (i_new_frame),
        .i_pos_x               (i_pos_x),
        .i_pos_y               (i_pos_y),
        .i_width               (i_width),
        .i_height              (i_height),
        .i_radius_top_left     (i_radius_top_left),
        .i_radius_top_right    (i_radius_top_right),
        .i_radius_bottom_right (i_radius_bottom_right),
        .i_radius_bottom_left  (i_radius_bottom_left),
        .i_fill_color          (i_fill_color),
        .empty                 (empty),
        .pop                   (pop),
        .o_vertex_x            (o_vertex_x),
        .o_vertex_y            (o_vertex_y),
        .o_vertex_color        (o_vertex_color),
        .o_has_triangle        (o_has_triangle),
        .o_tri_center          (o_tri_center),
        .o_tri_first           (o_tri_first),
        .o_tri_second          (o_tri_second),
        .o_overflow            (o_overflow),
        .o_last                (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // sin(k*90/S deg) in Q1.14, Taylor series in Q30
    function automatic longint sine_q14(input int unsigned k);
        longint unsigned ang;
        longint unsigned pw;
        longint          acc;
        longint          q;
        ang = (HALF_PI_Q30 * 64'(k) + 64'(CORNER_SEGMENTS / 2)) / 64'(CORNER_SEGMENTS);
        acc = longint'(ang);
        pw  = ang;
        for (int n = 1; n <= 12; n++) begin
            pw = (pw * ang) >> 30;
            pw = (pw * ang) >> 30;
            pw = pw / 64'(2 * n * (2 * n + 1));
            acc = (n % 2 == 1) ? acc - longint'(pw) : acc + longint'(pw);
        end
        if (acc < 0) begin
            acc = 0;
        end
        q = (acc + 32768) / 65536;
        return (q > Q14_ONE) ? Q14_ONE : q;
    endfunction

    // round half towards +inf by 2^sh, saturate to Q12.4
    function automatic logic signed [15:0] to_q12_4(input longint v, input int unsigned sh);
        longint r;
        r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return 16'(r);
    endfunction

    function automatic t_rect_req make_rect(input bit nf, input int px, input int py,
                                            input int w, input int h, input int tl,
                                            input int tr, input int br, input int bl,
                                            input bit [31:0] col);
        t_rect_req rq;
        rq.new_frame = nf;
        rq.pos_x     = 16'(px);
        rq.pos_y     = 16'(py);
        rq.width     = 15'(w);
        rq.height    = 15'(h);
        rq.rad[0]    = 15'(tl);
        rq.rad[1]    = 15'(tr);
        rq.rad[2]    = 15'(br);
        rq.rad[3]    = 15'(bl);
        rq.color     = col;
        return rq;
    endfunction

    function automatic bit [14:0] pick_extent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 15'h7fff;
            2, 3:    return 15'($urandom_range(0, 32767));
            default: return 15'($urandom_range(1, 4095));
        endcase
    endfunction

    function automatic bit signed [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3, 4: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic t_rect_req random_rect();
        t_rect_req rq;
        rq.new_frame = ($urandom_range(0, 5) == 0);
        rq.pos_x     = pick_coord();
        rq.pos_y     = pick_coord();
        rq.width     = pick_extent();
        rq.height    = pick_extent();
        for (int c = 0; c < 4; c++) begin
            rq.rad[c] = pick_extent();
        end
        rq.color = $urandom;
        return rq;
    endfunction

    task automatic predict_fan(input t_rect_req rq);
        longint      px, py, w, h, side, r2, cv, sv, sk, ck, base;
        longint      rad [4];
        longint      cx [4];
        longint      cy [4];
        int unsigned pt;
        t_result     res;
        t_corner     crn;
        if (rq.new_frame) begin
            vtx_used = 0;
            idx_used = 0;
        end
        if (vtx_used + FAN_PTS + 1 > VERTEX_CAPACITY ||
            idx_used + 3 * FAN_PTS > INDEX_CAPACITY) begin
            // dropped request: one overflow marker, counts untouched
            res          = '0;
            res.overflow = 1'b1;
            res.last     = 1'b1;
            fan_expected.push_back(res);
        end else begin
            px   = longint'(rq.pos_x);
            py   = longint'(rq.pos_y);
            w    = longint'(rq.width);
            h    = longint'(rq.height);
            side = (w < h) ? w : h;
            for (int c = 0; c < 4; c++) begin
                r2     = 2 * longint'(rq.rad[c]);
                rad[c] = (r2 < side) ? r2 : side;
            end
            // corner centres in 1/32 units
            cx[0] = 2 * px + rad[0];          cy[0] = 2 * py + rad[0];
            cx[1] = 2 * px + 2 * w - rad[1];  cy[1] = 2 * py + rad[1];
            cx[2] = 2 * px + 2 * w - rad[2];  cy[2] = 2 * py + 2 * h - rad[2];
            cx[3] = 2 * px + rad[3];          cy[3] = 2 * py + 2 * h - rad[3];
            base = vtx_used;

            res              = '0;
            res.vertex_x     = to_q12_4(2 * px + w, 1);
            res.vertex_y     = to_q12_4(2 * py + h, 1);
            res.vertex_color = rq.color;
            fan_expected.push_back(res);

            pt = 0;
            for (int c = 0; c < 4; c++) begin
                crn = t_corner'(c);
                for (int s = 0; s <= CORNER_SEGMENTS; s++) begin
                    sk = sine_lut[s];
                    ck = sine_lut[CORNER_SEGMENTS - s];
                    case (crn)
                        CRN_TL: begin
                            cv = -ck;
                            sv = -sk;
                        end
                        CRN_TR: begin
                            cv = sk;
                            sv = -ck;
                        end
                        CRN_BR: begin
                            cv = ck;
                            sv = sk;
                        end
                        default: begin
                            cv = -sk;
                            sv = ck;
                        end
                    endcase
                    res.vertex_x     = to_q12_4(cx[c] * Q14_ONE + rad[c] * cv, 15);
                    res.vertex_y     = to_q12_4(cy[c] * Q14_ONE + rad[c] * sv, 15);
                    res.has_triangle = 1'b1;
                    res.tri_center   = 16'(base);
                    res.tri_first    = 16'(base + 1 + pt);
                    res.tri_second   = 16'(base + 1 + (pt + 1) % FAN_PTS);
                    res.overflow     = 1'b0;
                    res.last         = (pt + 1 == FAN_PTS);
                    fan_expected.push_back(res);
                    pt++;
                end
            end
            vtx_used = (vtx_used + FAN_PTS + 1) & 'h1FFFF;
            idx_used = (idx_used + 3 * FAN_PTS) & 'h3FFFF;
        end
    endtask

    // entered and left just after a falling edge; push stays high between requests unless src_idle inserts a gap
    task automatic send_request(input t_rect_req rq);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_new_frame           <= rq.new_frame;
        i_pos_x               <= rq.pos_x;
        i_pos_y               <= rq.pos_y;
        i_width               <= rq.width;
        i_height              <= rq.height;
        i_radius_top_left     <= rq.rad[0];
        i_radius_top_right    <= rq.rad[1];
        i_radius_bottom_right <= rq.rad[2];
        i_radius_bottom_left  <= rq.rad[3];
        i_fill_color          <= rq.color;
        push                  <= 1'b1;
        do @(posedge i_clk); while (full);
        predict_fan(rq);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (fan_expected.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic test_directed_shapes();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_request(make_rect(1, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
        send_request(make_rect(0, 0, 0, 1600, 1600, 160, 160, 160, 160, 32'h1122_3344));
        // radii far beyond half the short side
        send_request(make_rect(0, 100, -200, 320, 160, 32767, 32767, 32767, 32767,
                               32'hffff_ffff));
        // negative halves round towards +inf
        send_request(make_rect(0, -1, -1, 1, 1, 1, 1, 1, 1, 32'ha5a5_a5a5));
        // far edges run past the Q12.4 range
        send_request(make_rect(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                               32'h5a5a_5a5a));
        send_request(make_rect(0, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 32'h0));
        send_request(make_rect(0, -32768, 32767, 32767, 1, 7, 0, 32767, 3, 32'h8000_0001));
        send_request(make_rect(0, 1234, -4321, 555, 777, 0, 100, 1000, 50, 32'h00ff_00ff));
        send_request(make_rect(1, 16, 16, 33, 17, 5, 9, 2, 11, 32'hff00_ff00));
        send_request(make_rect(0, 21845, -21846, 'h2aaa, 'h5555, 'h5555, 'h2aaa, 'h5555,
                               'h2aaa, 32'h7fff_fffe));
        send_request(make_rect(0, -21846, 21845, 'h5555, 'h2aaa, 'h2aaa, 'h5555, 'h2aaa,
                               'h5555, 32'h3c3c_c3c3));
        send_request(make_rect(1, -5000, 3000, 0, 4000, 500, 500, 500, 500, 32'h0102_0304));
        send_request(make_rect(0, 3000, -5000, 4000, 0, 500, 0, 500, 0, 32'h0403_0201));
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        sink_hold = HOLD_OFF;
        repeat (8) send_request(random_rect());
        wait_drained();
    endtask

    task automatic test_frame_accumulation();
        t_rect_req rq;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        // a long run inside one frame so the index base keeps climbing
        for (int n = 0; n < FRAME_RUN; n++) begin
            rq           = random_rect();
            rq.new_frame = (n == 0);
            send_request(rq);
        end
        rq           = random_rect();
        rq.new_frame = 1'b1;
        send_request(rq);
        wait_drained();
    endtask

    task automatic test_random_fans();
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 50 == 0) begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            send_request(random_rect());
        end
        wait_drained();
    endtask

    initial begin : result_sink
        int unsigned gap;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                pop <= 1'b0;
                repeat (sink_hold) @(negedge i_clk);
                sink_hold = 0;
            end
            gap = sink_idle ? $urandom_range(0, 11) : 0;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
            if (fan_expected.size() == 0) begin
                fails++;
                $display("%0t: result popped with no request outstanding, expected none, actual x=%0h y=%0h",
                         $time, o_vertex_x, o_vertex_y);
            end else begin
                want_res = fan_expected.pop_front();
                check_field("vertex_x", want_res.vertex_x, o_vertex_x);
                check_field("vertex_y", want_res.vertex_y, o_vertex_y);
                check_field("vertex_color", want_res.vertex_color, o_vertex_color);
                check_field("has_triangle", want_res.has_triangle, o_has_triangle);
                check_field("tri_center", want_res.tri_center, o_tri_center);
                check_field("tri_first", want_res.tri_first, o_tri_first);
                check_field("tri_second", want_res.tri_second, o_tri_second);
                check_field("overflow", want_res.overflow, o_overflow);
                check_field("last", want_res.last, o_last);
            end
        end
    end

    // cycles with neither a request nor a result moving
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n               = 1'b0;
        push                  = 1'b0;
        i_new_frame           = 1'b0;
        i_pos_x               = '0;
        i_pos_y               = '0;
        i_width               = '0;
        i_height              = '0;
        i_radius_top_left     = '0;
        i_radius_top_right    = '0;
        i_radius_bottom_right = '0;
        i_radius_bottom_left  = '0;
        i_fill_color          = '0;
        fails                 = 0;
        quiet_cycles          = 0;
        sink_hold             = 0;
        src_idle              = 1'b0;
        sink_idle             = 1'b0;
        vtx_used              = 0;
        idx_used              = 0;
        for (int k = 0; k <= CORNER_SEGMENTS; k++) begin
            sine_lut[k] = sine_q14(k);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_shapes();
        test_output_backpressure();
        test_frame_accumulation();
        test_random_fans();

        repeat (48) @(posedge i_clk);
        if (fails == 0 && fan_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
